// ===== sv/plp_pkg.sv =====
// Shared types, codes and helpers for the pen plotter line stepper.
package plp_pkg;

	// Grid geometry: cells per side, in the range 2 to 64
	localparam int GRID_SIZE = 64;
	localparam int COORD_W   = 6;
	localparam int LIM_W     = COORD_W + 1;
	localparam logic [LIM_W-1:0]   GRID_LIM = LIM_W'(GRID_SIZE);
	localparam logic [COORD_W-1:0] GRID_MAX = COORD_W'(GRID_SIZE - 1);

	// Command codes
	localparam logic [2:0] FUNC_PEN_UP   = 3'd0;
	localparam logic [2:0] FUNC_PEN_DOWN = 3'd1;
	localparam logic [2:0] FUNC_BOLD     = 3'd2;
	localparam logic [2:0] FUNC_NORMAL   = 3'd3;
	localparam logic [2:0] FUNC_MOVE     = 3'd4;

	// Move directions
	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;

	typedef struct packed {
		logic [2:0]         func;
		logic [1:0]         direction;
		logic [COORD_W-1:0] distance;
	} in_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_row;
		logic [COORD_W-1:0] pixel_col;
		logic               bold;
		logic               last;
	} out_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic move_go;
		logic rem_one;
		logic out_space;
	} status_t;

	// Saturate a start position onto the grid
	function automatic logic [COORD_W-1:0] clamp_to_grid(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] r;
		r = ({1'b0, v} < GRID_LIM) ? v : GRID_MAX;
		return r;
	endfunction

endpackage

// ===== sv/plp_ctrl.sv =====
// Sequencing controller: takes commands and drives the cell-by-cell stepping.
module plp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             cfg_valid,
	input  plp_pkg::status_t status,
	output plp_pkg::cmd_t    cmd,
	output logic             idle,
	output logic             busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_STEP = 1'b1;

	logic state_q;
	logic state_d;

	// Decode commands from the current state; a register beat waits while a command is offered
	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.cfg_wr = (state_q == ST_IDLE) && cfg_valid && !in_valid;
		cmd.step   = (state_q == ST_STEP) && status.out_space;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.move_go) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (status.out_space && status.rem_one) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign busy = (state_q == ST_STEP);

endmodule

// ===== sv/plp_datapath.sv =====
// Datapath: cursor, pen and brush state, step counter and pixel output register.
module plp_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plp_pkg::cmd_t                 cmd,
	input  plp_pkg::in_t                  in_data,
	input  logic [plp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [plp_pkg::COORD_W-1:0]   cfg_data,
	input  logic                          out_ready,
	output plp_pkg::status_t              status,
	output logic                          out_valid,
	output plp_pkg::out_t                 out_data,
	output logic [plp_pkg::COORD_W-1:0]   cursor_row,
	output logic [plp_pkg::COORD_W-1:0]   cursor_col
);

	logic [plp_pkg::COORD_W-1:0] row_q;
	logic [plp_pkg::COORD_W-1:0] col_q;
	logic                        pen_q;
	logic                        bold_q;
	logic [1:0]                  dir_q;
	logic [plp_pkg::COORD_W-1:0] rem_q;
	logic                        out_valid_q;
	plp_pkg::out_t               out_q;

	logic                        move_ok;
	logic [plp_pkg::COORD_W-1:0] row_nx;
	logic [plp_pkg::COORD_W-1:0] col_nx;

	// Check that the whole move stays on the grid
	always_comb begin
		case (in_data.direction)
			plp_pkg::DIR_NORTH: move_ok = in_data.distance <= row_q;
			plp_pkg::DIR_SOUTH: move_ok = ({1'b0, row_q} + {1'b0, in_data.distance})
				< plp_pkg::GRID_LIM;
			plp_pkg::DIR_EAST:  move_ok = ({1'b0, col_q} + {1'b0, in_data.distance})
				< plp_pkg::GRID_LIM;
			default:            move_ok = in_data.distance <= col_q;
		endcase
	end

	assign status.move_go   = (in_data.func == plp_pkg::FUNC_MOVE) && move_ok &&
		(in_data.distance != '0);
	assign status.rem_one   = (rem_q == plp_pkg::COORD_W'(1));
	assign status.out_space = !out_valid_q || out_ready;

	// Next cell one step along the latched direction
	always_comb begin
		row_nx = row_q;
		col_nx = col_q;
		case (dir_q)
			plp_pkg::DIR_NORTH: row_nx = row_q - plp_pkg::COORD_W'(1);
			plp_pkg::DIR_SOUTH: row_nx = row_q + plp_pkg::COORD_W'(1);
			plp_pkg::DIR_EAST:  col_nx = col_q + plp_pkg::COORD_W'(1);
			default:            col_nx = col_q - plp_pkg::COORD_W'(1);
		endcase
	end

	// Cursor, pen, brush and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			pen_q  <= 1'b0;
			bold_q <= 1'b0;
			rem_q  <= '0;
		end else if (cmd.cfg_wr) begin
			if (cfg_index == plp_pkg::CFG_START_ROW) begin
				row_q <= plp_pkg::clamp_to_grid(cfg_data);
			end else if (cfg_index == plp_pkg::CFG_START_COL) begin
				col_q <= plp_pkg::clamp_to_grid(cfg_data);
			end
		end else if (cmd.accept) begin
			case (in_data.func)
				plp_pkg::FUNC_PEN_UP:   pen_q  <= 1'b0;
				plp_pkg::FUNC_PEN_DOWN: pen_q  <= 1'b1;
				plp_pkg::FUNC_BOLD:     bold_q <= 1'b1;
				plp_pkg::FUNC_NORMAL:   bold_q <= 1'b0;
				plp_pkg::FUNC_MOVE: begin
					if (status.move_go) begin
						rem_q <= in_data.distance;
					end
				end
				default: ;
			endcase
		end else if (cmd.step) begin
			row_q <= row_nx;
			col_q <= col_nx;
			rem_q <= rem_q - plp_pkg::COORD_W'(1);
		end
	end

	// Latch the direction of an accepted move
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dir_q <= in_data.direction;
		end
	end

	// Output beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && pen_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (cmd.step && pen_q) begin
			out_q.pixel_row <= row_nx;
			out_q.pixel_col <= col_nx;
			out_q.bold      <= bold_q;
			out_q.last      <= status.rem_one;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign cursor_row = row_q;
	assign cursor_col = col_q;

endmodule

// ===== sv/pen_plotter_line_stepper.sv =====
// Top level of the pen plotter line stepper: controller plus datapath.
//
// Each input beat is one plotter command. Pen and brush commands, rejected
// moves, zero-length moves and unused codes are taken while idle and give no
// output. A legal move of D cells (up to 63) is accepted and then steps one
// cell per cycle while the output has room; with the pen down each step
// emits one pixel beat, last set on the final
// one. Stepping pauses while a pixel beat waits on out_ready, so the single
// output register and the consumer set the pace. A new command or a
// configuration write is taken only once the previous move has finished
// stepping; the final pixel of that move may still be waiting at the output.
// A configuration write is held off while a command is offered.
// Writing start_row or start_col moves the cursor there at once.
module pen_plotter_line_stepper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  plp_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output plp_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [plp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [plp_pkg::COORD_W-1:0]   cfg_data
);

	plp_pkg::cmd_t               cmd;
	plp_pkg::status_t            status;
	logic                        idle;
	logic                        busy;
	logic [plp_pkg::COORD_W-1:0] cursor_row;
	logic [plp_pkg::COORD_W-1:0] cursor_col;

	plp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.status    (status),
		.cmd       (cmd),
		.idle      (idle),
		.busy      (busy)
	);

	plp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_data    (in_data),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (out_ready),
		.status     (status),
		.out_valid  (out_valid),
		.out_data   (out_data),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col)
	);

	assign in_ready  = idle;
	assign cfg_ready = idle && !in_valid;

	// A pixel that is not the last of its move means the move is still stepping
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> busy)
		else $error("non-final pixel beat pending while idle");

	// The cursor never leaves the grid
	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cursor_row} < plp_pkg::GRID_LIM) && ({1'b0, cursor_col} < plp_pkg::GRID_LIM))
		else $error("cursor left the grid");

	// A step on the last remaining cell returns the block to idle
	a_last_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.rem_one |=> idle)
		else $error("stepping continued past the end of a move");

	// A legal move of nonzero length starts stepping on the next cycle
	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && status.move_go |=> busy && !$stable(busy))
		else $error("legal move did not start stepping");

endmodule
